[src/tcce_pkg.sv]
// shared types, constants and codes for the text console cursor engine
`default_nettype none

package tcce_pkg;

  // field widths
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;
  localparam int GLYPH_W    = 8;
  localparam int KIND_W     = 3;
  localparam int OP_W       = 3;
  localparam int TYPED_W    = 7;
  localparam int S_TDATA_W  = 16;
  localparam int M_TDATA_W  = 24;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_COLUMNS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TEXT_ROWS    = 1'd1;
  localparam logic [COL_W-1:0] COLS_RESET = 7'd50;
  localparam logic [ROW_W-1:0] ROWS_RESET = 6'd20;
  localparam logic [COL_W-1:0] COLS_MAX   = 7'd64;
  localparam logic [ROW_W-1:0] ROWS_MAX   = 6'd32;

  // parameter defaults
  localparam int LINE_CAPACITY_DEF = 64;
  localparam int TAB_STOP_DEF      = 4;

  // command budget per transaction
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W       = 6;

  // tab stop table covers every non-negative column
  localparam int TAB_TABLE_N = 2 ** (COL_W - 1);

  // position meaning "nowhere yet"
  localparam logic signed [COL_W-1:0] COL_NONE = '1;
  localparam logic signed [ROW_W-1:0] ROW_NONE = '1;

  // character codes
  localparam logic [GLYPH_W-1:0] CH_NUL    = 8'h00;
  localparam logic [GLYPH_W-1:0] CH_BS     = 8'h08;
  localparam logic [GLYPH_W-1:0] CH_TAB    = 8'h09;
  localparam logic [GLYPH_W-1:0] CH_LF     = 8'h0A;
  localparam logic [GLYPH_W-1:0] CH_CR     = 8'h0D;
  localparam logic [GLYPH_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [GLYPH_W-1:0] CH_PROMPT = 8'h3E;

  typedef enum logic [KIND_W-1:0] {
    KIND_TYPED   = 3'd0,
    KIND_PRINT   = 3'd1,
    KIND_NEWLINE = 3'd2,
    KIND_BLINK   = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_t;

  typedef enum logic [OP_W-1:0] {
    OP_ERASE      = 3'd0,
    OP_GLYPH      = 3'd1,
    OP_GLYPH_EMPH = 3'd2,
    OP_CURSOR     = 3'd3,
    OP_CLEAR_ROW  = 3'd4,
    OP_LINE_READY = 3'd5
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PC_ERASE,
    ST_PC_GLYPH,
    ST_LF_CURSOR,
    ST_LF_TEXT,
    ST_LF_PROMPT,
    ST_ENT_ERASE,
    ST_ENT_READY,
    ST_BS_CURSOR,
    ST_BS_TEXT,
    ST_BLINK
  } state_t;

  // operand pair for the position step unit
  typedef struct packed {
    logic signed [COL_W-1:0] col;
    logic signed [ROW_W-1:0] row;
  } pos_req_t;

  // every step the unit offers for the selected pair
  typedef struct packed {
    logic signed [COL_W-1:0] inc_col;
    logic                    col_full;
    logic                    inc_col_stop;
    logic signed [ROW_W-1:0] inc_row;
    logic                    row_full;
    logic signed [COL_W-1:0] dec_col;
    logic signed [ROW_W-1:0] dec_row;
  } pos_res_t;

  // one draw command
  typedef struct packed {
    op_t                     op;
    logic signed [COL_W-1:0] col;
    logic signed [ROW_W-1:0] row;
    logic [GLYPH_W-1:0]      glyph;
    logic                    last;
  } cmd_t;

endpackage

`default_nettype wire

[src/tcce_pos_unit.sv]
// shared position step unit: column/row advance, step back and wrap compares
`default_nettype none

module tcce_pos_unit #(
  parameter int TAB_STOP = tcce_pkg::TAB_STOP_DEF
) (
  input  tcce_pkg::pos_req_t              req,
  input  logic [tcce_pkg::COL_W-1:0]      ncols,
  input  logic [tcce_pkg::ROW_W-1:0]      nrows,
  output tcce_pkg::pos_res_t              res
);
  import tcce_pkg::*;

  logic signed [COL_W:0]   col_plus;
  logic signed [ROW_W-1:0] inc_row;
  logic                    col_pos;
  logic                    row_pos;
  logic [TAB_TABLE_N-1:0]  tab_hit;

  // columns that sit on a tab stop, fixed at elaboration
  for (genvar g = 0; g < TAB_TABLE_N; g++) begin : g_tab
    assign tab_hit[g] = ((g % TAB_STOP) == 0);
  end

  // forward steps with wrap compares against the clamped counts
  assign col_plus = $signed({req.col[COL_W-1], req.col}) + $signed((COL_W + 1)'(1));
  assign inc_row  = req.row + ROW_W'(1);

  // strictly positive tests for the step back
  assign col_pos = !req.col[COL_W-1] && (req.col != '0);
  assign row_pos = !req.row[ROW_W-1] && (req.row != '0);

  always_comb begin
    res.inc_col      = col_plus[COL_W-1:0];
    res.col_full     = (col_plus >= $signed({1'b0, ncols}));
    res.inc_col_stop = !col_plus[COL_W-1] && tab_hit[col_plus[COL_W-2:0]];
    res.inc_row      = inc_row;
    res.row_full     = ($signed({inc_row[ROW_W-1], inc_row}) >= $signed({1'b0, nrows}));
    // step back from col <= 0: end of the row above, or last row if row <= 0
    if (col_pos) begin
      res.dec_col = req.col - COL_W'(1);
      res.dec_row = req.row;
    end else begin
      res.dec_col = ncols - COL_W'(1);
      res.dec_row = row_pos ? (req.row - ROW_W'(1)) : (nrows - ROW_W'(1));
    end
  end

endmodule

`default_nettype wire

[src/tcce_out_stage.sv]
// output register for draw commands on the master stream side
`default_nettype none

module tcce_out_stage (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  tcce_pkg::cmd_t                    cmd,
  output logic                              out_free,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tcce_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic [tcce_pkg::OP_W-1:0]         m_tuser,
  output logic                              m_tlast
);
  import tcce_pkg::*;

  localparam int PAD_W = M_TDATA_W - COL_W - ROW_W - GLYPH_W;

  cmd_t held;

  // slot is free when empty or drained this cycle
  assign out_free = !m_tvalid || m_tready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // command payload
  always_ff @(posedge clk) begin
    if (push) begin
      held <= cmd;
    end
  end

  // tdata from bit 0: col, row, glyph, zero pad
  assign m_tdata = {PAD_W'(0), held.glyph, held.row, held.col};
  assign m_tuser = held.op;
  assign m_tlast = held.last;

endmodule

`default_nettype wire

[src/text_console_cursor_engine.sv]
// text console cursor engine: sequencer, position state and configuration
// a plain character is accepted, then takes two steps, erase and glyph, a command each;
// a line feed takes two steps plus one for a prompt, a tab repeats the character steps,
// a clear screen takes 2 * rows steps; all steps go through the one position step unit
// and wait whenever the output register is still held by the sink
// rst puts all positions at -1, shows the cursor, zeroes the typed count, loads 50 x 20
`default_nettype none

module text_console_cursor_engine #(
  parameter int LINE_CAPACITY = tcce_pkg::LINE_CAPACITY_DEF,
  parameter int TAB_STOP      = tcce_pkg::TAB_STOP_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [tcce_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // input items
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tcce_pkg::S_TDATA_W-1:0]     s_tdata,   // ch[7:0], emphasize[8], prompt[9]
  input  logic [tcce_pkg::KIND_W-1:0]        s_tuser,   // kind[2:0]
  // draw commands
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tcce_pkg::M_TDATA_W-1:0]     m_tdata,   // col[6:0], row[12:7], glyph[20:13]
  output logic [tcce_pkg::OP_W-1:0]          m_tuser,   // op[2:0]
  output logic                               m_tlast
);
  import tcce_pkg::*;

  localparam logic [TYPED_W:0] TYPED_LIMIT = (TYPED_W + 1)'(LINE_CAPACITY - 1);

  state_t state, state_next;

  // configuration and clamped counts
  logic [COL_W-1:0] text_columns;
  logic [ROW_W-1:0] text_rows;
  logic [COL_W-1:0] n_cols;
  logic [ROW_W-1:0] n_rows;

  // architectural state
  logic signed [COL_W-1:0] text_col, text_col_next;
  logic signed [ROW_W-1:0] text_row, text_row_next;
  logic signed [COL_W-1:0] cursor_col, cursor_col_next;
  logic signed [ROW_W-1:0] cursor_row, cursor_row_next;
  logic                    cursor_visible, cursor_visible_next;
  logic [TYPED_W-1:0]      typed_count, typed_count_next;

  // per transaction context
  logic [GLYPH_W-1:0] cur_glyph, cur_glyph_next;
  logic               cur_emph, cur_emph_next;
  logic               tab_mode, tab_mode_next;
  logic               lf_prompt, lf_prompt_next;
  logic               clear_mode, clear_mode_next;
  logic [ROW_W-1:0]   lines_left, lines_left_next;
  logic [CNT_W-1:0]   emit_count;

  // dispatch decode
  state_t             disp_state;
  logic [TYPED_W-1:0] disp_typed;
  logic [GLYPH_W-1:0] disp_glyph;
  logic               disp_emph;
  logic               disp_tab;
  logic               disp_prompt;
  logic               disp_clear;

  // input fields
  kind_t              in_kind;
  logic [GLYPH_W-1:0] in_ch;
  logic               in_emph;
  logic               in_prompt;

  // step control
  logic               s_accept;
  logic               out_free;
  logic               step_go;
  logic               emits;
  logic               more;
  logic               sel_text;
  logic               push;
  cmd_t               push_cmd;
  logic signed [ROW_W-1:0] row_new;
  logic               clear_again;

  pos_req_t pos_req;
  pos_res_t pos_res;

  assign in_kind   = kind_t'(s_tuser);
  assign in_ch     = s_tdata[GLYPH_W-1:0];
  assign in_emph   = s_tdata[GLYPH_W];
  assign in_prompt = s_tdata[GLYPH_W+1];

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign step_go  = (state != ST_IDLE) && out_free;

  // clamp the register values to the supported ranges
  always_comb begin
    if (text_columns == '0) begin
      n_cols = COL_W'(1);
    end else if (text_columns > COLS_MAX) begin
      n_cols = COLS_MAX;
    end else begin
      n_cols = text_columns;
    end
    if (text_rows == '0) begin
      n_rows = ROW_W'(1);
    end else if (text_rows > ROWS_MAX) begin
      n_rows = ROWS_MAX;
    end else begin
      n_rows = text_rows;
    end
  end

  // shared position unit works on the text pair or the cursor pair
  assign pos_req.col = sel_text ? text_col : cursor_col;
  assign pos_req.row = sel_text ? text_row : cursor_row;

  tcce_pos_unit #(
    .TAB_STOP (TAB_STOP)
  ) u_pos (
    .req   (pos_req),
    .ncols (n_cols),
    .nrows (n_rows),
    .res   (pos_res)
  );

  assign row_new     = pos_res.row_full ? ROW_W'(0) : pos_res.inc_row;
  assign clear_again = clear_mode && (lines_left > ROW_W'(1));

  // decode an incoming item into its first step
  always_comb begin
    disp_state  = ST_IDLE;
    disp_typed  = typed_count;
    disp_glyph  = in_ch;
    disp_emph   = 1'b0;
    disp_tab    = 1'b0;
    disp_prompt = 1'b0;
    disp_clear  = 1'b0;
    case (in_kind)
      KIND_TYPED: begin
        if (in_ch == CH_NUL) begin
          disp_state = ST_IDLE;
        end else if (in_ch == CH_LF) begin
          if (typed_count != '0) begin
            disp_state  = ST_ENT_ERASE;
            disp_prompt = 1'b1;
            disp_typed  = '0;
          end
        end else if (in_ch == CH_BS) begin
          if (typed_count != '0) begin
            disp_state = ST_BS_CURSOR;
            disp_typed = typed_count - TYPED_W'(1);
          end
        end else if ({1'b0, typed_count} < TYPED_LIMIT) begin
          disp_state = ST_PC_ERASE;
          disp_typed = typed_count + TYPED_W'(1);
        end
      end
      KIND_PRINT: begin
        if (in_ch == CH_CR) begin
          disp_state = ST_IDLE;
        end else if (in_ch == CH_LF) begin
          disp_state = ST_LF_CURSOR;
        end else if (in_ch == CH_TAB) begin
          disp_state = ST_PC_ERASE;
          disp_glyph = CH_SPACE;
          disp_tab   = 1'b1;
        end else begin
          disp_state = ST_PC_ERASE;
          disp_emph  = in_emph;
        end
      end
      KIND_NEWLINE: begin
        disp_state  = ST_LF_CURSOR;
        disp_prompt = in_prompt;
      end
      KIND_BLINK: begin
        disp_state = ST_BLINK;
      end
      KIND_CLEAR: begin
        disp_state = ST_LF_CURSOR;
        disp_clear = 1'b1;
      end
      default: begin
        disp_state = ST_IDLE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_accept) begin
          state_next = disp_state;
        end
      end
      ST_PC_ERASE: begin
        if (step_go) state_next = ST_PC_GLYPH;
      end
      ST_PC_GLYPH: begin
        if (step_go) begin
          if (pos_res.col_full) begin
            state_next = ST_LF_CURSOR;
          end else if (tab_mode && !pos_res.inc_col_stop) begin
            state_next = ST_PC_ERASE;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LF_CURSOR: begin
        if (step_go) state_next = ST_LF_TEXT;
      end
      ST_LF_TEXT: begin
        if (step_go) begin
          if (lf_prompt) begin
            state_next = ST_LF_PROMPT;
          end else if (clear_again) begin
            state_next = ST_LF_CURSOR;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_LF_PROMPT: begin
        if (step_go) state_next = ST_IDLE;
      end
      ST_ENT_ERASE: begin
        if (step_go) state_next = ST_ENT_READY;
      end
      ST_ENT_READY: begin
        if (step_go) state_next = ST_LF_CURSOR;
      end
      ST_BS_CURSOR: begin
        if (step_go) state_next = ST_BS_TEXT;
      end
      ST_BS_TEXT: begin
        if (step_go) state_next = ST_IDLE;
      end
      ST_BLINK: begin
        if (step_go) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // step outputs: unit operand select and the command of this step
  always_comb begin
    emits          = 1'b0;
    more           = 1'b0;
    sel_text       = 1'b0;
    push_cmd.op    = OP_ERASE;
    push_cmd.col   = cursor_col;
    push_cmd.row   = cursor_row;
    push_cmd.glyph = '0;
    case (state)
      ST_PC_ERASE: begin
        emits = 1'b1;
        more  = 1'b1;
      end
      ST_PC_GLYPH: begin
        sel_text       = 1'b1;
        emits          = 1'b1;
        push_cmd.op    = cur_emph ? OP_GLYPH_EMPH : OP_GLYPH;
        push_cmd.col   = text_col;
        push_cmd.row   = text_row;
        push_cmd.glyph = cur_glyph;
        more           = pos_res.col_full || (tab_mode && !pos_res.inc_col_stop);
      end
      ST_LF_TEXT: begin
        sel_text     = 1'b1;
        emits        = 1'b1;
        push_cmd.op  = OP_CLEAR_ROW;
        push_cmd.col = '0;
        push_cmd.row = row_new;
        more         = lf_prompt || clear_again;
      end
      ST_LF_PROMPT: begin
        emits          = 1'b1;
        push_cmd.op    = OP_GLYPH;
        push_cmd.col   = text_col;
        push_cmd.row   = text_row;
        push_cmd.glyph = CH_PROMPT;
      end
      ST_ENT_ERASE: begin
        emits = 1'b1;
        more  = 1'b1;
      end
      ST_ENT_READY: begin
        emits        = 1'b1;
        push_cmd.op  = OP_LINE_READY;
        push_cmd.col = '0;
        push_cmd.row = '0;
        more         = 1'b1;
      end
      ST_BS_CURSOR: begin
        emits = 1'b1;
        more  = 1'b1;
      end
      ST_BS_TEXT: begin
        sel_text     = 1'b1;
        emits        = 1'b1;
        push_cmd.col = pos_res.dec_col;
        push_cmd.row = pos_res.dec_row;
      end
      ST_BLINK: begin
        emits       = 1'b1;
        push_cmd.op = cursor_visible ? OP_CURSOR : OP_ERASE;
      end
      default: begin
        emits = 1'b0;
      end
    endcase
    push_cmd.last = !more || (emit_count == CNT_W'(MAX_RESULTS - 1));
  end

  // commands past the budget are dropped while the state still moves on
  assign push = step_go && emits && (emit_count < CNT_W'(MAX_RESULTS));

  // next values of position state and context
  always_comb begin
    text_col_next       = text_col;
    text_row_next       = text_row;
    cursor_col_next     = cursor_col;
    cursor_row_next     = cursor_row;
    cursor_visible_next = cursor_visible;
    typed_count_next    = typed_count;
    cur_glyph_next      = cur_glyph;
    cur_emph_next       = cur_emph;
    tab_mode_next       = tab_mode;
    lf_prompt_next      = lf_prompt;
    clear_mode_next     = clear_mode;
    lines_left_next     = lines_left;
    if (s_accept) begin
      typed_count_next = disp_typed;
      cur_glyph_next   = disp_glyph;
      cur_emph_next    = disp_emph;
      tab_mode_next    = disp_tab;
      lf_prompt_next   = disp_prompt;
      clear_mode_next  = disp_clear;
      lines_left_next  = n_rows;
    end else if (step_go) begin
      case (state)
        ST_PC_ERASE: begin
          cursor_col_next = pos_res.inc_col;
        end
        ST_PC_GLYPH: begin
          if (!pos_res.col_full) begin
            text_col_next = pos_res.inc_col;
          end
        end
        ST_LF_CURSOR: begin
          cursor_col_next = '0;
          cursor_row_next = pos_res.inc_row;
        end
        ST_LF_TEXT: begin
          text_col_next = '0;
          text_row_next = row_new;
          if (pos_res.row_full) begin
            cursor_row_next = '0;
          end
          if (clear_again) begin
            lines_left_next = lines_left - ROW_W'(1);
          end else if (clear_mode) begin
            // end of a clear screen parks every position
            text_col_next   = COL_NONE;
            text_row_next   = ROW_NONE;
            cursor_col_next = COL_NONE;
            cursor_row_next = ROW_NONE;
          end
        end
        ST_LF_PROMPT: begin
          text_col_next   = COL_W'(1);
          cursor_col_next = COL_W'(1);
        end
        ST_BS_CURSOR: begin
          cursor_col_next = pos_res.dec_col;
          cursor_row_next = pos_res.dec_row;
        end
        ST_BS_TEXT: begin
          text_col_next = pos_res.dec_col;
          text_row_next = pos_res.dec_row;
        end
        ST_BLINK: begin
          cursor_visible_next = !cursor_visible;
        end
        default: begin
          cursor_visible_next = cursor_visible;
        end
      endcase
    end
  end

  // control and position registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      text_columns   <= COLS_RESET;
      text_rows      <= ROWS_RESET;
      text_col       <= COL_NONE;
      text_row       <= ROW_NONE;
      cursor_col     <= COL_NONE;
      cursor_row     <= ROW_NONE;
      cursor_visible <= 1'b1;
      typed_count    <= '0;
      cur_emph       <= 1'b0;
      tab_mode       <= 1'b0;
      lf_prompt      <= 1'b0;
      clear_mode     <= 1'b0;
      lines_left     <= '0;
      emit_count     <= '0;
    end else begin
      state          <= state_next;
      text_col       <= text_col_next;
      text_row       <= text_row_next;
      cursor_col     <= cursor_col_next;
      cursor_row     <= cursor_row_next;
      cursor_visible <= cursor_visible_next;
      typed_count    <= typed_count_next;
      cur_emph       <= cur_emph_next;
      tab_mode       <= tab_mode_next;
      lf_prompt      <= lf_prompt_next;
      clear_mode     <= clear_mode_next;
      lines_left     <= lines_left_next;
      if (s_accept) begin
        emit_count <= '0;
      end else if (push) begin
        emit_count <= emit_count + CNT_W'(1);
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TEXT_COLUMNS: text_columns <= cfg_wdata;
          REG_TEXT_ROWS:    text_rows    <= cfg_wdata[ROW_W-1:0];
          default:          text_rows    <= text_rows;
        endcase
      end
    end
  end

  // glyph of the current transaction
  always_ff @(posedge clk) begin
    cur_glyph <= cur_glyph_next;
  end

  tcce_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .cmd      (push_cmd),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // a command is only loaded into a free output slot
  a_push_free: assert property (@(posedge clk) disable iff (rst)
    push |-> out_free)
    else $error("command pushed into a held output register");

  // the command budget never overflows
  a_budget: assert property (@(posedge clk) disable iff (rst)
    emit_count <= CNT_W'(MAX_RESULTS))
    else $error("command count beyond budget");

  // a final command that is not forced by the budget ends the transaction
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    push && push_cmd.last && (emit_count != CNT_W'(MAX_RESULTS - 1))
      |=> (state == ST_IDLE))
    else $error("sequencer kept running after the final command");

  // between transactions the text column is never below the parked position
  a_text_col_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (text_col >= COL_NONE))
    else $error("text column below the parked position");

  // a clear screen always has a line left when it draws one
  a_clear_lines: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LF_TEXT) && clear_mode |-> (lines_left != '0))
    else $error("clear screen ran out of rows");

endmodule

`default_nettype wire

[verif/text_console_cursor_engine_tb.sv]
// self-checking testbench for the text console cursor engine draw command stream
module text_console_cursor_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tcce_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int MAX_WAIT      = 17;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 80;
  localparam int REPORT_MAX    = 10;

  // kinds the block leaves alone
  localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_UNUSED_C = 3'd7;

  localparam cmd_t NO_CMD = '0;

  // one directed row: item fields, then an optional hand-written result
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [GLYPH_W-1:0] ch;
    logic               emph;
    logic               prm;
    logic               fixed;    // result below replaces the prediction
    logic               has_cmd;  // fixed row emits exactly one command
    cmd_t               cmd;
  } stim_row_t;

  localparam int N_DIRECTED = 25;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // blink right after reset: cursor shown, then erased, at the unset cell
    '{KIND_BLINK, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b1,
      '{OP_CURSOR, COL_NONE, ROW_NONE, CH_NUL, 1'b1}},
    '{KIND_BLINK, CH_NUL, 1'b0, 1'b0, 1'b1, 1'b1,
      '{OP_ERASE, COL_NONE, ROW_NONE, CH_NUL, 1'b1}},
    // enter, backspace and nul with nothing typed, return, spare kinds: silent
    '{KIND_TYPED, CH_LF, 1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{KIND_TYPED, CH_BS, 1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{KIND_TYPED, CH_NUL, 1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
    '{KIND_PRINT, CH_CR, 1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
    '{KIND_UNUSED_A, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
    '{KIND_UNUSED_B, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
    '{KIND_UNUSED_C, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, NO_CMD},
    // print: plain, emphasized top code, tab, LF; newline, prompt or not
    '{KIND_PRINT, 8'h41, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_PRINT, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_PRINT, CH_TAB, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_PRINT, CH_LF, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_NEWLINE, CH_NUL, 1'b0, 1'b1, 1'b0, 1'b0, NO_CMD},
    '{KIND_NEWLINE, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    // line editing: type, back out past the start, type again
    '{KIND_TYPED, 8'h68, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_TYPED, 8'h69, 1'b1, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_TYPED, CH_BS, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_TYPED, CH_BS, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_TYPED, CH_BS, 1'b0, 1'b0, 1'b1, 1'b0, NO_CMD},
    '{KIND_TYPED, 8'h71, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    // clear keeps the typed count, so backspace then steps back from column -1
    '{KIND_CLEAR, CH_NUL, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_TYPED, CH_BS, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_TYPED, 8'h78, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD},
    '{KIND_TYPED, CH_LF, 1'b0, 1'b0, 1'b0, 1'b0, NO_CMD}
  };

  // geometry phases; -1 draws a random register value
  localparam int N_PHASES = 8;
  localparam int PHASE_COLS  [N_PHASES] = '{0, 127, 64, 5, 1, -1, -1, 50};
  localparam int PHASE_ROWS  [N_PHASES] = '{0, 127, 32, 3, 64, -1, -1, 20};
  localparam int PHASE_ITEMS [N_PHASES] = '{25, 40, 75, 40, 30, 40, 40, 40};
  localparam int PHASE_LONG  [N_PHASES] = '{0, 0, 1, 0, 0, 0, 0, 0};

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata;   // ch[7:0], emphasize[8], prompt[9]
  logic [KIND_W-1:0]      s_tuser;   // kind[2:0]
  logic                   m_tvalid;
  logic                   m_tready;
  logic [M_TDATA_W-1:0]   m_tdata;   // col[6:0], row[12:7], glyph[20:13]
  logic [OP_W-1:0]        m_tuser;   // op[2:0]
  logic                   m_tlast;

  text_console_cursor_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // console state as the testbench sees it
  int                 pos_tcol, pos_trow, pos_ccol, pos_crow;
  bit                 cursor_on;
  int                 typed_len;
  logic [COL_W-1:0]   cols_setting;
  logic [ROW_W-1:0]   rows_setting;

  cmd_t new_cmds[$];   // commands of the item being predicted
  cmd_t cmds_due[$];   // draw commands still to arrive, oldest first

  int mismatches;
  int item_count;
  int cmd_count;
  int setting_count;
  int send_burst;
  int sink_burst;
  int cycle_count;

  function automatic int wrap_col(int v);
    return ((v + (1 << (COL_W - 1))) & ((1 << COL_W) - 1)) - (1 << (COL_W - 1));
  endfunction

  function automatic int wrap_row(int v);
    return ((v + (1 << (ROW_W - 1))) & ((1 << ROW_W) - 1)) - (1 << (ROW_W - 1));
  endfunction

  function int cols_used();
    if (cols_setting == 0) return 1;
    if (cols_setting > COLS_MAX) return int'(COLS_MAX);
    return int'(cols_setting);
  endfunction

  function int rows_used();
    if (rows_setting == 0) return 1;
    if (rows_setting > ROWS_MAX) return int'(ROWS_MAX);
    return int'(rows_setting);
  endfunction

  // commands past the per-item budget are dropped
  function void push_cmd(op_t op, int col, int row, logic [GLYPH_W-1:0] g);
    cmd_t c;
    if (new_cmds.size() >= MAX_RESULTS) return;
    c.op    = op;
    c.col   = col[COL_W-1:0];
    c.row   = row[ROW_W-1:0];
    c.glyph = g;
    c.last  = 1'b0;
    new_cmds.push_back(c);
  endfunction

  function void feed_line(bit with_prompt);
    pos_tcol = 0;
    pos_ccol = 0;
    pos_trow = wrap_row(pos_trow + 1);
    pos_crow = wrap_row(pos_crow + 1);
    if (pos_trow >= rows_used()) begin
      pos_trow = 0;
      pos_crow = 0;
    end
    push_cmd(OP_CLEAR_ROW, 0, pos_trow, CH_NUL);
    if (with_prompt) begin
      pos_ccol = wrap_col(pos_ccol + 1);
      push_cmd(OP_GLYPH, pos_tcol, pos_trow, CH_PROMPT);
      pos_tcol = wrap_col(pos_tcol + 1);
    end
  endfunction

  function void put_glyph(logic [GLYPH_W-1:0] c, bit emph);
    push_cmd(OP_ERASE, pos_ccol, pos_crow, CH_NUL);
    pos_ccol = wrap_col(pos_ccol + 1);
    push_cmd(emph ? OP_GLYPH_EMPH : OP_GLYPH, pos_tcol, pos_trow, c);
    if (pos_tcol + 1 >= cols_used()) feed_line(1'b0);
    else pos_tcol = wrap_col(pos_tcol + 1);
  endfunction

  // a negative column wraps to the end of the row above, last row past the top
  function void step_back();
    push_cmd(OP_ERASE, pos_ccol, pos_crow, CH_NUL);
    pos_tcol = pos_tcol - 1;
    if (pos_tcol < 0) begin
      pos_trow = pos_trow - 1;
      if (pos_trow < 0) pos_trow = rows_used() - 1;
      pos_tcol = cols_used() - 1;
    end
    pos_tcol = wrap_col(pos_tcol);
    pos_trow = wrap_row(pos_trow);
    push_cmd(OP_ERASE, pos_tcol, pos_trow, CH_NUL);
    if (pos_ccol > 0) begin
      pos_ccol = pos_ccol - 1;
    end else begin
      pos_crow = pos_crow - 1;
      if (pos_crow < 0) pos_crow = rows_used() - 1;
      pos_ccol = cols_used() - 1;
    end
    pos_ccol = wrap_col(pos_ccol);
    pos_crow = wrap_row(pos_crow);
    typed_len = typed_len - 1;
  endfunction

  // draw commands one input item causes, with state update
  function void predict_commands(logic [KIND_W-1:0] kind, logic [GLYPH_W-1:0] ch,
                                 bit emph, bit prm);
    int n;
    new_cmds.delete();
    case (kind)
      KIND_TYPED: begin
        if (ch == CH_LF) begin
          if (typed_len != 0) begin
            push_cmd(OP_ERASE, pos_ccol, pos_crow, CH_NUL);
            push_cmd(OP_LINE_READY, 0, 0, CH_NUL);
            typed_len = 0;
            feed_line(1'b1);
          end
        end else if (ch == CH_BS) begin
          if (typed_len != 0) step_back();
        end else if (ch != CH_NUL && typed_len < LINE_CAPACITY_DEF - 1) begin
          put_glyph(ch, 1'b0);
          typed_len = typed_len + 1;
        end
      end
      KIND_PRINT: begin
        if (ch == CH_LF) begin
          feed_line(1'b0);
        end else if (ch == CH_TAB) begin
          // at least one space, then up to the next tab stop
          do put_glyph(CH_SPACE, 1'b0);
          while (!(pos_tcol >= 0 && pos_tcol % TAB_STOP_DEF == 0));
        end else if (ch != CH_CR) begin
          put_glyph(ch, emph);
        end
      end
      KIND_NEWLINE: feed_line(prm);
      KIND_BLINK: begin
        push_cmd(cursor_on ? OP_CURSOR : OP_ERASE, pos_ccol, pos_crow, CH_NUL);
        cursor_on = !cursor_on;
      end
      KIND_CLEAR: begin
        n = rows_used();
        repeat (n) feed_line(1'b0);
        pos_tcol = -1;
        pos_trow = -1;
        pos_ccol = -1;
        pos_crow = -1;
      end
      default: ;
    endcase
    if (new_cmds.size() > 0) new_cmds[new_cmds.size()-1].last = 1'b1;
  endfunction

  // wait length per transaction, with runs of back-to-back traffic
  function automatic int next_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 1) == 1) return $urandom_range(0, 2);
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // one input transaction; valid stays up when the next one follows at once
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [GLYPH_W-1:0] ch,
                           input logic emph, input logic prm, input bit fixed,
                           input bit has_cmd, input cmd_t fixed_cmd);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_TDATA_W - GLYPH_W - 2){1'b0}}, prm, emph, ch};
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_commands(kind, ch, emph, prm);
    if (!fixed) begin
      foreach (new_cmds[i]) cmds_due.push_back(new_cmds[i]);
    end else if (has_cmd) begin
      cmds_due.push_back(fixed_cmd);
    end
    item_count++;
    gap = next_wait(send_burst);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off input until every command is out and the block has settled
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [CFG_DATA_W-1:0] cols,
                              input logic [CFG_DATA_W-1:0] rows);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TEXT_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_index <= REG_TEXT_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cols_setting = cols;
    rows_setting = rows[ROW_W-1:0];
    setting_count++;
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d commands outstanding",
             cycle_count, cmds_due.size());
    $display("** text_console_cursor_engine: FAILED **");
    $finish;
  end

  // draw command sink and checker
  initial begin : sink
    cmd_t got;
    cmd_t want;
    int   stall;
    m_tready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = next_wait(sink_burst);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      got.op    = op_t'(m_tuser);
      got.col   = m_tdata[COL_W-1:0];
      got.row   = m_tdata[COL_W+ROW_W-1:COL_W];
      got.glyph = m_tdata[COL_W+ROW_W+GLYPH_W-1:COL_W+ROW_W];
      got.last  = m_tlast;
      cmd_count++;
      if (cmds_due.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("%0t: unexpected command op %0d col %0d row %0d glyph %02h last %0d",
                   $realtime, got.op, got.col, got.row, got.glyph, got.last);
        mismatches++;
      end else begin
        want = cmds_due.pop_front();
        if (got.op !== want.op || got.col !== want.col || got.row !== want.row ||
            got.glyph !== want.glyph || got.last !== want.last) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: mismatch, expected op %0d col %0d row %0d glyph %02h last %0d",
                     $realtime, want.op, want.col, want.row, want.glyph, want.last);
            $display("%0t:           got      op %0d col %0d row %0d glyph %02h last %0d",
                     $realtime, got.op, got.col, got.row, got.glyph, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin : stim
    logic [KIND_W-1:0]     kind;
    logic [GLYPH_W-1:0]    ch;
    logic                  emph;
    logic                  prm;
    logic [CFG_DATA_W-1:0] gcols;
    logic [CFG_DATA_W-1:0] grows;

    rst       = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;

    pos_tcol      = -1;
    pos_trow      = -1;
    pos_ccol      = -1;
    pos_crow      = -1;
    cursor_on     = 1'b1;
    typed_len     = 0;
    cols_setting  = COLS_RESET;
    rows_setting  = ROWS_RESET;
    mismatches    = 0;
    item_count    = 0;
    cmd_count     = 0;
    setting_count = 0;
    send_burst    = 0;
    sink_burst    = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed rows under the reset geometry
    foreach (DIRECTED[i])
      send_item(DIRECTED[i].kind, DIRECTED[i].ch, DIRECTED[i].emph, DIRECTED[i].prm,
                DIRECTED[i].fixed, DIRECTED[i].has_cmd, DIRECTED[i].cmd);
    wait_idle();

    // random traffic, one geometry per phase, no clear between phases
    for (int p = 0; p < N_PHASES; p++) begin
      gcols = (PHASE_COLS[p] < 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                  : CFG_DATA_W'(PHASE_COLS[p]);
      grows = (PHASE_ROWS[p] < 0) ? CFG_DATA_W'($urandom_range(0, 127))
                                  : CFG_DATA_W'(PHASE_ROWS[p]);
      set_geometry(gcols, grows);
      for (int k = 0; k < PHASE_ITEMS[p]; k++) begin
        if ($urandom_range(0, 29) == 0) wait_idle();
        if (PHASE_LONG[p] != 0) begin
          // one long typed line, to run into the line capacity
          kind = KIND_TYPED;
          ch   = ($urandom_range(0, 24) == 0) ? CH_BS : GLYPH_W'($urandom_range(1, 255));
          if (ch == CH_LF) ch = CH_SPACE;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:37]: begin
              kind = KIND_TYPED;
              case ($urandom_range(0, 19))
                0, 1, 2: ch = CH_LF;
                3, 4, 5: ch = CH_BS;
                6:       ch = CH_NUL;
                default: ch = GLYPH_W'($urandom_range(0, 255));
              endcase
            end
            [38:72]: begin
              kind = KIND_PRINT;
              case ($urandom_range(0, 9))
                0:       ch = CH_CR;
                1:       ch = CH_LF;
                2, 3:    ch = CH_TAB;
                default: ch = GLYPH_W'($urandom_range(0, 255));
              endcase
            end
            [73:82]: begin
              kind = KIND_NEWLINE;
              ch   = GLYPH_W'($urandom_range(0, 255));
            end
            [83:92]: begin
              kind = KIND_BLINK;
              ch   = GLYPH_W'($urandom_range(0, 255));
            end
            [93:95]: begin
              kind = KIND_CLEAR;
              ch   = GLYPH_W'($urandom_range(0, 255));
            end
            [96:97]: begin
              kind = KIND_W'($urandom_range(KIND_UNUSED_A, KIND_UNUSED_C));
              ch   = GLYPH_W'($urandom_range(0, 255));
            end
            default: begin
              kind = KIND_W'($urandom_range(0, (1 << KIND_W) - 1));
              ch   = GLYPH_W'($urandom_range(0, 255));
            end
          endcase
        end
        emph = 1'($urandom_range(0, 1));
        prm  = 1'($urandom_range(0, 1));
        send_item(kind, ch, emph, prm, 1'b0, 1'b0, NO_CMD);
      end
      wait_idle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d input transactions and %0d draw command transactions over %0d geometries",
             item_count, cmd_count, setting_count);
    $display("covered line editing up to capacity, tabs, prompts, blink, clear and wraps");
    if (mismatches == 0 && cmds_due.size() == 0) begin
      $display("** text_console_cursor_engine: PASSED **");
    end else begin
      $display("%0d mismatches, %0d commands never arrived", mismatches, cmds_due.size());
      $display("** text_console_cursor_engine: FAILED **");
    end
    $finish;
  end

endmodule

[text_console_cursor_engine.f]
src/tcce_pkg.sv
src/tcce_pos_unit.sv
src/tcce_out_stage.sv
src/text_console_cursor_engine.sv
verif/text_console_cursor_engine_tb.sv
